// ===== rtl/core/rdo_pkg.sv =====
// Shared types, codes and constants for the rover drive obstacle controller.
// No dependencies.
package rdo_pkg;

  localparam int unsigned SampleWindow = 10000;
  localparam int unsigned SampleW      = 14;

  // Truncating divide by 58 as multiply by ceil(2^18 / 58) and shift.
  // Exact for every count up to the sample window.
  localparam int unsigned            CmShift = 18;
  localparam logic [12:0]            CmRecip = 13'd4520;
  localparam int unsigned            ProdW   = SampleW + 13;

  localparam logic [7:0] CmdAuto    = 8'hFF;
  localparam logic [7:0] CmdForward = 8'h01;
  localparam logic [7:0] CmdBack    = 8'h02;
  localparam logic [7:0] CmdLeft    = 8'h04;
  localparam logic [7:0] CmdRight   = 8'h08;
  localparam logic [7:0] CmdStop    = 8'h0A;

  localparam logic [7:0] DriveOff     = 8'h00;
  localparam logic [7:0] DriveFwd     = 8'h44;
  localparam logic [7:0] DriveBack    = 8'h42;
  localparam logic [7:0] DriveLeft    = 8'h24;
  localparam logic [7:0] DriveCruise  = 8'h04;

  typedef enum logic [1:0] {
    RegObstacleCm   = 2'd0,
    RegReverseTicks = 2'd1,
    RegTurnTicks    = 2'd2,
    RegHoldTicks    = 2'd3
  } reg_idx_e;

  typedef enum logic [7:0] {
    StInit     = 8'b0000_0001,
    StStart    = 8'b0000_0010,
    StCtrl     = 8'b0000_0100,
    StCruise   = 8'b0000_1000,
    StReverse  = 8'b0001_0000,
    StTurn     = 8'b0010_0000,
    StHold     = 8'b0100_0000,
    StResetDrv = 8'b1000_0000
  } mode_e;

  function automatic logic [2:0] mode_code(mode_e st);
    logic [2:0] c;
    unique case (st)
      StInit:     c = 3'd0;
      StStart:    c = 3'd1;
      StCtrl:     c = 3'd2;
      StCruise:   c = 3'd3;
      StReverse:  c = 3'd4;
      StTurn:     c = 3'd5;
      StHold:     c = 3'd6;
      StResetDrv: c = 3'd7;
      default:    c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] inc_sat(logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// ===== rtl/core/rover_drive_obstacle_fsm.sv =====
// Top level of the rover drive controller with obstacle avoidance.
// Depends on rdo_pkg and rdo_dist.
//
// One request per control tick: an optional command byte plus an echo sample
// count. The block takes a request every clock cycle while in_stall_o is low
// and returns one result per request (input register, then the state update
// and divide-by-58 multiply into the result register). Throughput is
// set only by the result register: a stalled result holds one request in the
// input register, after which in_stall_o rises. Configuration registers are
// written through the cfg port, which is always ready.
module rover_drive_obstacle_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        rx_valid_i,
  input  logic [7:0]                  rx_byte_i,
  input  logic [rdo_pkg::SampleW-1:0] echo_samples_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  motor_drive_o,
  output logic [7:0]                  command_echo_o,
  output logic [7:0]                  distance_cm_o,
  output logic [2:0]                  mode_o
);
  import rdo_pkg::*;

  // configuration
  logic [7:0] obstacle_cm_q, reverse_ticks_q, turn_ticks_q, hold_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_cm_q   <= 8'd30;
      reverse_ticks_q <= 8'd100;
      turn_ticks_q    <= 8'd100;
      hold_ticks_q    <= 8'd30;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegObstacleCm:   obstacle_cm_q   <= cfg_data_i;
        RegReverseTicks: reverse_ticks_q <= cfg_data_i;
        RegTurnTicks:    turn_ticks_q    <= cfg_data_i;
        RegHoldTicks:    hold_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid_q;
  logic               s1_rx_valid_q;
  logic [7:0]         s1_rx_byte_q;
  logic [SampleW-1:0] s1_samples_q;
  logic               advance;

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_rx_valid_q <= rx_valid_i;
      s1_rx_byte_q  <= rx_byte_i;
      s1_samples_q  <= echo_samples_i;
    end
  end

  // state update
  logic [7:0] dist_cm;

  rdo_dist u_dist (
    .samples_i  (s1_samples_q),
    .distance_o (dist_cm)
  );

  mode_e      state_q, state_d;
  logic [7:0] command_q, command_d;
  logic [7:0] man_cnt_q, man_cnt_d, man_mid;
  logic [7:0] hold_cnt_q, hold_cnt_d, hold_mid;
  logic [7:0] drive_q, drive_d;
  logic       auto_mode;

  always_comb begin
    command_d = s1_rx_valid_q ? s1_rx_byte_q : command_q;
    auto_mode = (command_d == CmdAuto);
    state_d   = state_q;
    man_mid   = man_cnt_q;
    hold_mid  = hold_cnt_q;

    unique case (state_q)
      StInit:  state_d = StStart;
      StStart: state_d = auto_mode ? StCruise : StCtrl;
      StCtrl: begin
        if (auto_mode) begin
          state_d = StCruise;
        end else begin
          hold_mid = 8'd0;
          state_d  = StHold;
        end
      end
      StHold: begin
        if (hold_cnt_q >= hold_ticks_q) state_d = StResetDrv;
      end
      StResetDrv: state_d = StCtrl;
      StCruise: begin
        if (!auto_mode) begin
          state_d = StCtrl;
        end else if (dist_cm <= obstacle_cm_q) begin
          state_d = StReverse;
          man_mid = 8'd0;
        end
      end
      StReverse: begin
        if (!auto_mode) begin
          state_d = StCtrl;
        end else if (man_cnt_q >= reverse_ticks_q) begin
          state_d = StTurn;
          man_mid = 8'd0;
        end
      end
      StTurn: begin
        if (!auto_mode) state_d = StCtrl;
        else if (man_cnt_q >= turn_ticks_q) state_d = StCruise;
      end
      default: state_d = StInit;
    endcase

    man_cnt_d  = man_mid;
    hold_cnt_d = hold_mid;
    drive_d    = drive_q;

    unique case (state_d)
      StCruise: drive_d = DriveCruise;
      StReverse: begin
        man_cnt_d = inc_sat(man_mid);
        drive_d   = DriveBack;
      end
      StTurn: begin
        man_cnt_d = inc_sat(man_mid);
        drive_d   = DriveLeft;
      end
      StStart, StResetDrv: drive_d = DriveOff;
      StCtrl: begin
        // unknown commands leave the motor byte alone
        priority if (command_d == CmdStop)    drive_d = DriveOff;
        else if     (command_d == CmdForward) drive_d = DriveFwd;
        else if     (command_d == CmdBack)    drive_d = DriveBack;
        else if     (command_d == CmdLeft)    drive_d = DriveLeft;
        else if     (command_d == CmdRight)   drive_d = DriveFwd;
        else                                  drive_d = drive_q;
      end
      StHold: hold_cnt_d = inc_sat(hold_mid);
      default: ;
    endcase
  end

  logic update;
  assign update = advance && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StInit;
      command_q  <= 8'd0;
      man_cnt_q  <= 8'd0;
      hold_cnt_q <= 8'd0;
      drive_q    <= 8'd0;
    end else if (update) begin
      state_q    <= state_d;
      command_q  <= command_d;
      man_cnt_q  <= man_cnt_d;
      hold_cnt_q <= hold_cnt_d;
      drive_q    <= drive_d;
    end
  end

  // result register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update) begin
      motor_drive_o  <= drive_d;
      command_echo_o <= command_d;
      distance_cm_o  <= dist_cm;
      mode_o         <= mode_code(state_d);
    end
  end

endmodule

// ===== rtl/core/rdo_dist.sv =====
// Echo sample count to distance in cm: clamp to the sample window, divide by 58.
// Depends on rdo_pkg.
module rdo_dist (
  input  logic [rdo_pkg::SampleW-1:0] samples_i,
  output logic [7:0]                  distance_o
);
  import rdo_pkg::*;

  localparam logic [SampleW-1:0] Window = SampleW'(SampleWindow);

  logic [SampleW-1:0] clamped;
  logic [ProdW-1:0]   prod;
  logic [ProdW-1:0]   quot;

  assign clamped = (samples_i > Window) ? Window : samples_i;
  assign prod    = ProdW'(clamped) * ProdW'(CmRecip);
  assign quot    = prod >> CmShift;
  // quotient tops out at 172, saturation kept for safety
  assign distance_o = (quot > ProdW'(255)) ? 8'hFF : quot[7:0];

endmodule
